>>> hw/rtl/otsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// otsu_pkg
// Shared types and constants for the Otsu threshold finder.
// -----------------------------------------------------------------------------
package otsu_pkg;

  localparam int MAX_PIXELS_LOG2_DEF = 20;
  localparam int LEVELS              = 256;

  // multiplier operation select
  localparam logic [1:0] MUL_SQ  = 2'd0;  // a * a
  localparam logic [1:0] MUL_LHS = 2'd1;  // sq * best den
  localparam logic [1:0] MUL_RHS = 2'd2;  // best sq * den

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic       overflow;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic       acc_en;    // histogram read-modify-write for the input word
    logic       sw_start;  // clear sweep sums and best score
    logic       sw_rd;     // issue bin read at sweep index
    logic       sw_step;   // add read bin to running sums
    logic       sw_eval;   // class products
    logic       sw_diff;   // difference and denominator
    logic       mul_ld;    // load multiplier operands
    logic       mul_wr;    // store multiplier product
    logic [1:0] mul_op;
    logic       sw_upd;    // keep t when its score is greater
    logic       clr;       // clear bin at sweep index
    logic       tot_clr;   // clear totals
  } otsu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ok;          // both classes non-empty at current t
    logic t_last;      // current t is 255
    logic idx_last;    // sweep index at 255
    logic mul_done;    // multiplier idle
  } otsu_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/otsu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// otsu_datapath
// Histogram memory, totals, sweep sums and exact score compare.
// -----------------------------------------------------------------------------
module otsu_datapath #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire [7:0]                in_pixel,
  input  wire otsu_pkg::otsu_cmd_t cmd,
  output otsu_pkg::otsu_sts_t      sts,
  output logic [7:0]               best_t,
  output logic                     sat
);
  localparam int CW = MAX_PIXELS_LOG2 + 1;  // count width
  localparam int SW = MAX_PIXELS_LOG2 + 9;  // sum width
  localparam int PW = SW + CW;              // product width
  localparam int QW = 2 * PW;               // square width
  localparam int DW = 2 * CW;               // denominator width
  localparam int XW = QW + DW;              // cross product width
  localparam int YD = (PW + 7) / 8;         // multiplier digits of 8 bits
  localparam int YW = 8 * YD;
  localparam logic [CW-1:0] CAP = CW'(1) << MAX_PIXELS_LOG2;

  logic [CW-1:0] mem [otsu_pkg::LEVELS];
  logic [CW-1:0] rd_q;
  logic [7:0]    rd_addr;
  logic [7:0]    wr_addr_r;
  logic          wr_pend_r;
  logic          fwd_r;      // write-back in flight hit the same bin
  logic [CW-1:0] wr_val_r;   // last value written back
  logic [CW-1:0] wr_val;

  logic [CW-1:0] n_r;
  logic [SW-1:0] s_r;
  logic          sat_r;
  logic [7:0]    idx_r;
  logic [7:0]    t_r;

  logic [CW-1:0] n0_r;
  logic [SW-1:0] s0_r;
  logic [CW-1:0] n1_r;
  logic [PW-1:0] p_r, q_r, a_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] sq_r;
  logic [XW-1:0] lhs_r, rhs_r;
  logic [QW-1:0] bsq_r;
  logic [DW-1:0] bden_r;
  logic [7:0]    bt_r;
  logic          ok;

  // digit-serial multiplier, most significant digit first
  logic [QW-1:0] mx_r;
  logic [YW-1:0] my_r;
  logic [XW-1:0] macc_r;
  logic [3:0]    mcnt_r;
  logic [QW+7:0] mpp;

  assign rd_addr = cmd.acc_en ? in_pixel : idx_r;
  assign wr_val  = (fwd_r ? wr_val_r : rd_q) + CW'(1);

  // bin read, write-back of increment or clear
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_pend_r) begin
      mem[wr_addr_r] <= wr_val;
    end else if (cmd.clr) begin
      mem[idx_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
      fwd_r     <= 1'b0;
      n_r       <= '0;
      s_r       <= '0;
      sat_r     <= 1'b0;
      idx_r     <= '0;
    end else begin
      wr_pend_r <= 1'b0;
      if (cmd.acc_en) begin
        if (n_r >= CAP) begin
          sat_r <= 1'b1;
        end else begin
          wr_pend_r <= 1'b1;
          // the read at this edge misses the write-back landing at this edge
          fwd_r     <= wr_pend_r && (wr_addr_r == in_pixel);
          n_r       <= n_r + CW'(1);
          s_r       <= s_r + SW'(in_pixel);
        end
      end
      if (cmd.tot_clr) begin
        n_r   <= '0;
        s_r   <= '0;
        sat_r <= 1'b0;
      end
      if (cmd.sw_start) begin
        idx_r <= '0;
      end else if (cmd.sw_rd || cmd.clr) begin
        idx_r <= idx_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      wr_addr_r <= in_pixel;
    end
    if (wr_pend_r) begin
      wr_val_r <= wr_val;
    end
  end

  assign ok = (n0_r != '0) && (n0_r < n_r);

  // sweep: read, accumulate, products, difference
  always_ff @(posedge clk) begin
    if (cmd.sw_start) begin
      n0_r <= '0;
      s0_r <= '0;
    end else if (cmd.sw_step) begin
      n0_r <= n0_r + rd_q;
      s0_r <= s0_r + SW'(rd_q * t_r);
    end
    if (cmd.sw_rd) begin
      t_r <= idx_r;
    end
    if (cmd.sw_eval) begin
      n1_r <= n_r - n0_r;
      p_r  <= PW'(s_r - s0_r) * PW'(n0_r);
      q_r  <= PW'(s0_r) * PW'(n_r - n0_r);
    end
    if (cmd.sw_diff) begin
      a_r   <= (p_r >= q_r) ? p_r - q_r : q_r - p_r;
      den_r <= DW'(n0_r) * DW'(n1_r);
    end
  end

  assign mpp = (QW+8)'(mx_r) * (QW+8)'(my_r[YW-1 -: 8]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else if (cmd.mul_ld) begin
      mcnt_r <= 4'(YD);
    end else if (mcnt_r != 4'd0) begin
      mcnt_r <= mcnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      macc_r <= '0;
      unique case (cmd.mul_op)
        otsu_pkg::MUL_SQ: begin
          mx_r <= QW'(a_r);
          my_r <= YW'(a_r);
        end
        otsu_pkg::MUL_LHS: begin
          mx_r <= sq_r;
          my_r <= YW'(bden_r);
        end
        default: begin
          mx_r <= bsq_r;
          my_r <= YW'(den_r);
        end
      endcase
    end else if (mcnt_r != 4'd0) begin
      macc_r <= (macc_r << 8) + XW'(mpp);
      my_r   <= my_r << 8;
    end
    if (cmd.mul_wr) begin
      unique case (cmd.mul_op)
        otsu_pkg::MUL_SQ:  sq_r  <= macc_r[QW-1:0];
        otsu_pkg::MUL_LHS: lhs_r <= macc_r;
        default:           rhs_r <= macc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sw_start) begin
      bsq_r  <= '0;
      bden_r <= DW'(1);
      bt_r   <= '0;
    end else if (cmd.sw_upd && (lhs_r > rhs_r)) begin
      bsq_r  <= sq_r;
      bden_r <= den_r;
      bt_r   <= t_r;
    end
  end

  assign sts = '{ok: ok, t_last: (t_r == 8'd255), idx_last: (idx_r == 8'd255),
                 mul_done: (mcnt_r == 4'd0)};
  assign best_t = bt_r;
  assign sat    = sat_r;

endmodule
`default_nettype wire

>>> hw/rtl/otsu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// otsu_ctrl
// Sequencer: clear, accumulate, sweep thresholds, emit.
// -----------------------------------------------------------------------------
module otsu_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire                      in_last,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire                      out_stall,
  output otsu_pkg::otsu_cmd_t      cmd,
  input  wire otsu_pkg::otsu_sts_t sts
);
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_WAIT = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_STEP = 4'd4;
  localparam logic [3:0] S_EVAL = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_MLD  = 4'd7;
  localparam logic [3:0] S_MRUN = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  logic       acc;

  assign acc       = (st_r == S_ACC) && in_valid;
  assign in_stall  = (st_r != S_ACC);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    cmd          = '0;
    cmd.acc_en   = acc;
    cmd.sw_start = acc && in_last;
    cmd.sw_rd    = (st_r == S_RD);
    cmd.sw_step  = (st_r == S_STEP);
    cmd.sw_eval  = (st_r == S_EVAL);
    cmd.sw_diff  = (st_r == S_DIFF);
    cmd.mul_ld   = (st_r == S_MLD);
    cmd.mul_wr   = (st_r == S_MRUN) && sts.mul_done;
    cmd.mul_op   = op_r;
    cmd.sw_upd   = (st_r == S_CMP);
    cmd.clr      = (st_r == S_CLR);
    cmd.tot_clr  = (st_r == S_OUT) && !out_stall;
    st_nxt = st_r;
    op_nxt = op_r;
    unique case (st_r)
      S_CLR:   if (sts.idx_last) st_nxt = S_ACC;
      S_ACC:   if (acc && in_last) st_nxt = S_WAIT;
      S_WAIT:  st_nxt = S_RD;  // last write-back settles
      S_RD:    st_nxt = S_STEP;
      S_STEP:  st_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.ok) begin
          st_nxt = S_DIFF;
        end else if (sts.t_last) begin
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_RD;
        end
      end
      S_DIFF: begin
        st_nxt = S_MLD;
        op_nxt = otsu_pkg::MUL_SQ;
      end
      S_MLD:   st_nxt = S_MRUN;
      S_MRUN: begin
        if (sts.mul_done) begin
          if (op_r == otsu_pkg::MUL_RHS) begin
            st_nxt = S_CMP;
          end else begin
            st_nxt = S_MLD;
            op_nxt = (op_r == otsu_pkg::MUL_SQ) ? otsu_pkg::MUL_LHS : otsu_pkg::MUL_RHS;
          end
        end
      end
      S_CMP:   st_nxt = sts.t_last ? S_OUT : S_RD;
      S_OUT:   if (!out_stall) st_nxt = S_CLR;
      default: st_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      op_r <= otsu_pkg::MUL_SQ;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/otsu_threshold_finder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// otsu_threshold_finder_top
// Histogram-based Otsu threshold search for 8-bit grayscale images.
// -----------------------------------------------------------------------------
// Pixels: one word per cycle while accumulating (bin read-modify-write).
// Last pixel: its write-back lands in a wait state, then 256 thresholds are
// swept; where both classes are non-empty each takes three 7-digit multiplies
// at default width before its score is compared.
// After the result is taken a pass clears all 256 bins; input stalls.
// Reset is synchronous: control and totals clear, then the same clearing pass.
module otsu_threshold_finder_top #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire otsu_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output otsu_pkg::out_word_t     out_data
);
  otsu_pkg::otsu_cmd_t cmd;
  otsu_pkg::otsu_sts_t sts;
  logic [7:0] best_t;
  logic       sat;

  otsu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_data.last),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  otsu_datapath #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_pixel(in_data.pixel), .cmd(cmd), .sts(sts),
    .best_t(best_t), .sat(sat)
  );

  assign out_data = '{threshold: best_t, overflow: sat};

  a_no_take_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
